### hw/rtl/uer_pkg.sv
// ============================================================================
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ============================================================================
package uer_pkg;

    // measurement phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_FALL = 2'd3
    } phase_t;

    // per-transaction status flags carried down the pipeline
    typedef struct packed {
        logic trigger;
        logic busy;
        logic done;
        logic timed_out;
        logic new_meas;
    } flags_t;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd1;
    localparam logic [2:0] REG_SCALE_Q24     = 3'd2;
    localparam logic [2:0] REG_MIN_CM        = 3'd3;
    localparam logic [2:0] REG_MAX_CM        = 3'd4;

    // register reset values
    localparam logic [15:0] TRIGGER_TICKS_RST = 16'd10;
    localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd50000;
    localparam logic [23:0] SCALE_Q24_RST     = 24'd287728;
    localparam logic [9:0]  MIN_CM_RST        = 10'd2;
    localparam logic [9:0]  MAX_CM_RST        = 10'd400;

    // field widths
    localparam int ELAPSED_W = 20;
    localparam int SCALE_W   = 24;
    localparam int PULSE_W   = 16;
    localparam int DIST_W    = 11;

    // distance limits and decimal split constants
    localparam logic [DIST_W-1:0] DIST_MAX    = 11'd2047;
    localparam logic [9:0]        DIGIT_CLAMP = 10'd999;
    localparam logic [DIST_W-1:0] TEN         = 11'd10;
    localparam logic [DIST_W-1:0] HUNDRED     = 11'd100;
    // c / 100 == (c * 41) >> 12 for c <= 999
    localparam logic [15:0]       RECIP_100   = 16'd41;
    // r / 10 == (r * 205) >> 11 for r <= 99
    localparam logic [14:0]       RECIP_10    = 15'd205;

endpackage

### hw/rtl/ultrasonic_echo_ranger.sv
// ============================================================================
// ultrasonic_echo_ranger
// Echo-pulse ranging: trigger pulse, echo timing, fixed-point distance and
// decimal display digits, one result transaction per input tick.
// ============================================================================
// Every input transaction is one time tick (echo sample and start request)
// and produces exactly one result transaction. A new tick is taken every
// clock cycle while the result side keeps up. Behind the phase logic a
// tick passes a stage that registers its flags and pulse count, one for
// the count x scale multiply, one for the rounding and saturation of the
// distance, and the output register, which also holds the range check and
// the decimal digits. Back-pressure on the
// result side stalls the whole pipeline and deasserts s_axis_tready.
// Configuration is written over the APB port at byte address 4 * index.
// ============================================================================
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNT_BITS      = 16,
    parameter int SCALE_FRAC_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,

    // tick stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] echo, [1] start_req, [7:2] zero
    input  logic [7:0]  s_axis_tdata,

    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] trigger, [1] busy_res, [2] done_res, [3] timed_out,
    // [19:4] pulse_count, [30:20] span_cm, [31] in_range,
    // [35:32] hundreds, [39:36] tens, [43:40] ones, [45:44] blank_digits,
    // [47:46] zero
    output logic [47:0] m_axis_tdata,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PROD_W = COUNT_BITS + SCALE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SCALE_FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        trigger_ticks_reg;
    logic [19:0]        timeout_ticks_reg;
    logic [SCALE_W-1:0] scale_q24_reg;
    logic [9:0]         min_cm_reg;
    logic [9:0]         max_cm_reg;
    logic [2:0]         reg_idx;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel & penable & pwrite & pready;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            scale_q24_reg     <= SCALE_Q24_RST;
            min_cm_reg        <= MIN_CM_RST;
            max_cm_reg        <= MAX_CM_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_TRIGGER_TICKS: trigger_ticks_reg <= pwdata[15:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[19:0];
                REG_SCALE_Q24:     scale_q24_reg     <= pwdata[SCALE_W-1:0];
                REG_MIN_CM:        min_cm_reg        <= pwdata[9:0];
                REG_MAX_CM:        max_cm_reg        <= pwdata[9:0];
                default:           ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (reg_idx)
            REG_TRIGGER_TICKS: prdata = 32'(trigger_ticks_reg);
            REG_TIMEOUT_TICKS: prdata = 32'(timeout_ticks_reg);
            REG_SCALE_Q24:     prdata = 32'(scale_q24_reg);
            REG_MIN_CM:        prdata = 32'(min_cm_reg);
            REG_MAX_CM:        prdata = 32'(max_cm_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline handshake: all stages move together
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic advance;
    logic in_accept;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_accept     = s_axis_tvalid && advance;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // measurement control state
    // ------------------------------------------------------------------
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic [ELAPSED_W-1:0]   elapsed_next;
    logic [COUNT_BITS-1:0]  high_count_reg;
    logic [COUNT_BITS-1:0]  high_count_next;
    logic [COUNT_BITS-1:0]  held_pulse_reg;
    logic [COUNT_BITS-1:0]  held_pulse_next;
    logic                   echo_last_reg;

    logic                   echo;
    logic                   start_req;
    logic                   rise;
    phase_t                 ph_work;
    logic [ELAPSED_W-1:0]   el_work;
    logic [ELAPSED_W-1:0]   el_inc;
    flags_t                 flags_next;

    assign echo      = s_axis_tdata[0];
    assign start_req = s_axis_tdata[1];
    assign rise      = echo && !echo_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= '0;
            high_count_reg <= '0;
            held_pulse_reg <= '0;
            echo_last_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            high_count_reg <= high_count_next;
            held_pulse_reg <= held_pulse_next;
            echo_last_reg  <= echo;
        end
    end

    // next phase, timers and flags for this tick
    always_comb
    begin
        ph_work         = phase_reg;
        el_work         = elapsed_reg;
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        high_count_next = high_count_reg;
        held_pulse_next = held_pulse_reg;
        flags_next      = '0;

        if ((phase_reg == PH_IDLE) && start_req)
        begin
            ph_work = PH_TRIG;
            el_work = '0;
        end
        el_inc = el_work + ELAPSED_W'(1);

        case (ph_work)
            PH_TRIG:
            begin
                flags_next.trigger = 1'b1;
                if (el_inc >= ELAPSED_W'(trigger_ticks_reg))
                begin
                    phase_next   = PH_RISE;
                    elapsed_next = '0;
                end
                else
                begin
                    phase_next   = PH_TRIG;
                    elapsed_next = el_inc;
                end
            end
            PH_RISE, PH_FALL:
            begin
                phase_next = ph_work;
                if (ph_work == PH_RISE)
                begin
                    if (rise)
                    begin
                        phase_next      = PH_FALL;
                        high_count_next = COUNT_BITS'(1);
                    end
                end
                else if (echo)
                begin
                    high_count_next = high_count_reg + COUNT_BITS'(1);
                end
                else
                begin
                    // falling edge ends the measurement
                    held_pulse_next     = high_count_reg;
                    flags_next.done     = 1'b1;
                    flags_next.new_meas = 1'b1;
                    phase_next          = PH_IDLE;
                    elapsed_next        = '0;
                end
                if (!flags_next.done)
                begin
                    if (el_inc >= timeout_ticks_reg)
                    begin
                        flags_next.timed_out = 1'b1;
                        phase_next           = PH_IDLE;
                        elapsed_next         = '0;
                    end
                    else
                    begin
                        elapsed_next = el_inc;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        flags_next.busy = (phase_next != PH_IDLE);
    end

    // ------------------------------------------------------------------
    // stage 1: flags and pulse count of the tick
    // ------------------------------------------------------------------
    flags_t                s1_flags_reg;
    logic [COUNT_BITS-1:0] s1_pulse_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_flags_reg <= flags_next;
            s1_pulse_reg <= held_pulse_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: count x scale
    // ------------------------------------------------------------------
    flags_t              s2_flags_reg;
    logic [PULSE_W-1:0]  s2_pulse_reg;
    logic [PROD_W-1:0]   s2_prod_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_flags_reg <= s1_flags_reg;
            s2_pulse_reg <= PULSE_W'(s1_pulse_reg);
            s2_prod_reg  <= PROD_W'(s1_pulse_reg) * PROD_W'(scale_q24_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: round, saturate and hold the distance
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]   round_sum;
    logic [SUM_W-1:0]   round_shift;
    logic [DIST_W-1:0]  dist_new;
    flags_t             s3_flags_reg;
    logic [PULSE_W-1:0] s3_pulse_reg;
    logic [DIST_W-1:0]  held_dist_reg;

    assign round_sum   = SUM_W'(s2_prod_reg) + HALF;
    assign round_shift = round_sum >> SCALE_FRAC_BITS;
    assign dist_new    = (round_shift > SUM_W'(DIST_MAX)) ? DIST_MAX
                                                          : round_shift[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_dist_reg <= '0;
        end
        else if (advance && v2_reg && s2_flags_reg.new_meas)
        begin
            held_dist_reg <= dist_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_flags_reg <= s2_flags_reg;
            s3_pulse_reg <= s2_pulse_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: range check, decimal digits, output register
    // ------------------------------------------------------------------
    logic [9:0]   clamp_d;
    logic [15:0]  hund_prod;
    logic [3:0]   hund_d;
    logic [9:0]   hund_sub;
    logic [9:0]   rem_wide;
    logic [6:0]   rem_d;
    logic [14:0]  tens_prod;
    logic [3:0]   tens_d;
    logic [6:0]   tens_sub;
    logic [6:0]   ones_wide;
    logic         in_range_d;
    logic [1:0]   blank_d;

    assign clamp_d    = (held_dist_reg > DIST_W'(DIGIT_CLAMP)) ? DIGIT_CLAMP
                                                               : held_dist_reg[9:0];
    assign hund_prod  = 16'(clamp_d) * RECIP_100;
    assign hund_d     = hund_prod[15:12];
    assign hund_sub   = 10'(hund_d) * 10'(HUNDRED);
    assign rem_wide   = clamp_d - hund_sub;
    assign rem_d      = rem_wide[6:0];
    assign tens_prod  = 15'(rem_d) * RECIP_10;
    assign tens_d     = tens_prod[14:11];
    assign tens_sub   = 7'(tens_d) * 7'(TEN);
    assign ones_wide  = rem_d - tens_sub;
    assign in_range_d = (held_dist_reg >= DIST_W'(min_cm_reg)) &&
                        (held_dist_reg <= DIST_W'(max_cm_reg));

    // leading blank positions
    always_comb
    begin
        if (held_dist_reg < TEN)
        begin
            blank_d = 2'd2;
        end
        else if (held_dist_reg < HUNDRED)
        begin
            blank_d = 2'd1;
        end
        else
        begin
            blank_d = 2'd0;
        end
    end

    flags_t             out_flags_reg;
    logic [PULSE_W-1:0] out_pulse_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_in_range_reg;
    logic [3:0]         out_hund_reg;
    logic [3:0]         out_tens_reg;
    logic [3:0]         out_ones_reg;
    logic [1:0]         out_blank_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_flags_reg    <= s3_flags_reg;
            out_pulse_reg    <= s3_pulse_reg;
            out_dist_reg     <= held_dist_reg;
            out_in_range_reg <= in_range_d;
            out_hund_reg     <= hund_d;
            out_tens_reg     <= tens_d;
            out_ones_reg     <= ones_wide[3:0];
            out_blank_reg    <= blank_d;
        end
    end

    // result transaction packing
    assign m_axis_tdata = {
        2'b00,
        out_blank_reg,
        out_ones_reg,
        out_tens_reg,
        out_hund_reg,
        out_in_range_reg,
        out_dist_reg,
        out_pulse_reg,
        out_flags_reg.timed_out,
        out_flags_reg.done,
        out_flags_reg.busy,
        out_flags_reg.trigger
    };

endmodule

### tb/ultrasonic_echo_ranger_tb.sv
// ============================================================================
// ultrasonic_echo_ranger_tb
// Self-checking bench for the echo ranger: one tick transaction in, one
// reading transaction out. A tick driver and a reading monitor run as
// clocked processes; an in-bench ranger model predicts every reading.
// Directed cases come first, then randomized measurements under several
// register settings.
// ============================================================================
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb
    import uer_pkg::*;
();

    localparam int FRAC_BITS     = 24;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int HOLD_AFTER    = 600;
    localparam int HOLD_CYCLES   = 200;
    localparam int MAX_REPORTS   = 10;

    // one input tick
    typedef struct {
        logic echo;
        logic start;
    } tick_t;

    // one ranger reading, fields as they sit on the result stream
    typedef struct {
        logic                trigger;
        logic                busy;
        logic                done;
        logic                timed_out;
        logic [PULSE_W-1:0]  pulse;
        logic [DIST_W-1:0]   span;
        logic                in_range;
        logic [3:0]          hundreds;
        logic [3:0]          tens;
        logic [3:0]          ones;
        logic [1:0]          blank;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] echo, [1] start_req, [7:2] zero
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] trigger, [1] busy_res, [2] done_res, [3] timed_out, [19:4] pulse_count,
    // [30:20] span_cm, [31] in_range, [35:32] hundreds, [39:36] tens,
    // [43:40] ones, [45:44] blank_digits, [47:46] zero
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ultrasonic_echo_ranger dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // stimulus and scoreboard storage
    tick_t    tick_q[$];
    reading_t pending_readings[$];

    // register copies seen by the ranger model
    logic [15:0] cfg_trigger = TRIGGER_TICKS_RST;
    logic [19:0] cfg_timeout = TIMEOUT_TICKS_RST;
    logic [23:0] cfg_scale   = SCALE_Q24_RST;
    logic [9:0]  cfg_min     = MIN_CM_RST;
    logic [9:0]  cfg_max     = MAX_CM_RST;

    // ranger model state
    phase_t              phase_m = PH_IDLE;
    logic [19:0]         elapsed_m = '0;
    logic [PULSE_W-1:0]  high_count_m = '0;
    logic                echo_last_m = 1'b0;
    logic [PULSE_W-1:0]  held_pulse_m = '0;
    logic [DIST_W-1:0]   held_dist_m = '0;

    // bookkeeping
    int  mismatch_count = 0;
    int  results_seen = 0;
    int  ticks_taken = 0;
    int  meas_done = 0;
    int  meas_timeout = 0;
    int  cfg_writes = 0;
    int  cycle_count = 0;
    bit  steady = 1'b0;
    bit  tick_done = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // count x scale in Q0.24, rounded half up, saturated to the 11-bit field
    function automatic logic [DIST_W-1:0] scale_distance(input logic [PULSE_W-1:0] cnt);
        logic [PULSE_W+SCALE_W:0] prod;
        logic [PULSE_W+SCALE_W:0] whole;
        prod  = cnt * cfg_scale + (41'd1 << (FRAC_BITS - 1));
        whole = prod >> FRAC_BITS;
        return (whole > DIST_MAX) ? DIST_MAX : whole[DIST_W-1:0];
    endfunction

    // advance the ranger model by one tick and form the expected reading
    task automatic step_ranger(input logic echo, input logic start, output reading_t r);
        logic               rise;
        logic               fin;
        logic [DIST_W-1:0]  clamped;
        rise = echo && !echo_last_m;
        fin = 1'b0;
        r.trigger = 1'b0;
        r.timed_out = 1'b0;

        if (phase_m == PH_IDLE && start)
        begin
            phase_m = PH_TRIG;
            elapsed_m = '0;
        end

        if (phase_m == PH_TRIG)
        begin
            r.trigger = 1'b1;
            elapsed_m = elapsed_m + 20'd1;
            // zero trigger length behaves as one tick
            if (elapsed_m >= cfg_trigger)
            begin
                phase_m = PH_RISE;
                elapsed_m = '0;
            end
        end
        else if (phase_m != PH_IDLE)
        begin
            if (phase_m == PH_RISE)
            begin
                if (rise)
                begin
                    phase_m = PH_FALL;
                    high_count_m = PULSE_W'(1);
                end
            end
            else if (echo)
                high_count_m = high_count_m + PULSE_W'(1);
            else
            begin
                // falling edge: latch count and distance
                held_pulse_m = high_count_m;
                held_dist_m = scale_distance(high_count_m);
                fin = 1'b1;
                phase_m = PH_IDLE;
                elapsed_m = '0;
            end
            if (!fin)
            begin
                elapsed_m = elapsed_m + 20'd1;
                if (elapsed_m >= cfg_timeout)
                begin
                    r.timed_out = 1'b1;
                    phase_m = PH_IDLE;
                    elapsed_m = '0;
                end
            end
        end
        echo_last_m = echo;

        clamped = (held_dist_m > DIGIT_CLAMP) ? DIGIT_CLAMP : held_dist_m;
        r.busy = (phase_m != PH_IDLE);
        r.done = fin;
        r.pulse = held_pulse_m;
        r.span = held_dist_m;
        r.in_range = (held_dist_m >= cfg_min) && (held_dist_m <= cfg_max);
        r.hundreds = 4'(clamped / 100);
        r.tens = 4'((clamped / 10) % 10);
        r.ones = 4'(clamped % 10);
        r.blank = (held_dist_m < 10) ? 2'd2 : ((held_dist_m < 100) ? 2'd1 : 2'd0);
    endtask

    function automatic reading_t unpack_reading(input logic [47:0] d);
        reading_t r;
        r.trigger   = d[0];
        r.busy      = d[1];
        r.done      = d[2];
        r.timed_out = d[3];
        r.pulse     = d[19:4];
        r.span      = d[30:20];
        r.in_range  = d[31];
        r.hundreds  = d[35:32];
        r.tens      = d[39:36];
        r.ones      = d[43:40];
        r.blank     = d[45:44];
        return r;
    endfunction

    function automatic void compare_field(input string label, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("reading %0d: %s expected %0d, got %0d", results_seen, label,
                         want, got);
        end
    endfunction

    // tick driver: changes on the falling edge
    always @(negedge clk)
    begin : drive_ticks
        tick_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || tick_done)
        begin
            if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (tick_q.size() != 0)
            begin
                nxt = tick_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'b0, nxt.start, nxt.echo};
                gap_left <= (steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // reading receiver: random stalls plus one long hold-off with ticks still queued
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (!hold_done && results_seen >= HOLD_AFTER && tick_q.size() > 100)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // monitor: check readings, then predict for accepted ticks
    always @(posedge clk)
    begin : watch_streams
        reading_t got;
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got = unpack_reading(m_axis_tdata);
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("reading %0d arrived with nothing expected", results_seen);
            end
            else
            begin
                want = pending_readings.pop_front();
                compare_field("trigger", want.trigger, got.trigger);
                compare_field("busy", want.busy, got.busy);
                compare_field("done", want.done, got.done);
                compare_field("timed_out", want.timed_out, got.timed_out);
                compare_field("pulse_count", want.pulse, got.pulse);
                compare_field("span_cm", want.span, got.span);
                compare_field("in_range", want.in_range, got.in_range);
                compare_field("hundreds", want.hundreds, got.hundreds);
                compare_field("tens", want.tens, got.tens);
                compare_field("ones", want.ones, got.ones);
                compare_field("blank_digits", want.blank, got.blank);
            end
        end
        tick_done <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            step_ranger(s_axis_tdata[0], s_axis_tdata[1], want);
            pending_readings.push_back(want);
            ticks_taken++;
            meas_done += want.done;
            meas_timeout += want.timed_out;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // register write: setup then access, model copy follows at the write edge
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_TRIGGER_TICKS: cfg_trigger = value[15:0];
            REG_TIMEOUT_TICKS: cfg_timeout = value[19:0];
            REG_SCALE_Q24:     cfg_scale = value[23:0];
            REG_MIN_CM:        cfg_min = value[9:0];
            REG_MAX_CM:        cfg_max = value[9:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_ranger(input logic [31:0] trig, input logic [31:0] tmo,
                                  input logic [31:0] scale, input logic [31:0] lo,
                                  input logic [31:0] hi);
        apb_write(REG_TRIGGER_TICKS, trig);
        apb_write(REG_TIMEOUT_TICKS, tmo);
        apb_write(REG_SCALE_Q24, scale);
        apb_write(REG_MIN_CM, lo);
        apb_write(REG_MAX_CM, hi);
    endtask

    // block idle: every tick sent and every reading back, plus pipeline slack
    task automatic wait_drained();
        while (tick_q.size() != 0 || s_axis_tvalid || pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_tick(input logic echo, input logic start);
        tick_t t;
        t.echo = echo;
        t.start = start;
        tick_q.push_back(t);
    endtask

    // occasional start request while a measurement is running
    function automatic logic stray_start();
        return $urandom_range(0, 15) == 0;
    endfunction

    // start, trigger, quiet wait, echo pulse, quiet tail
    task automatic queue_measurement(input int wait_len, input int high_len);
        int trig_len;
        trig_len = (cfg_trigger == 0) ? 1 : cfg_trigger;
        push_tick(1'($urandom_range(0, 1)), 1'b1);
        for (int i = 1; i < trig_len; i++)
            push_tick(1'($urandom_range(0, 1)), stray_start());
        for (int i = 0; i < wait_len; i++)
            push_tick(1'b0, stray_start());
        for (int i = 0; i < high_len; i++)
            push_tick(1'b1, stray_start());
        repeat ($urandom_range(1, 4)) push_tick(1'b0, 1'b0);
    endtask

    // measurement that cannot finish: no echo, echo stuck high, or echo too long
    task automatic queue_timeout_run();
        int trig_len;
        int flavor;
        trig_len = (cfg_trigger == 0) ? 1 : cfg_trigger;
        flavor = $urandom_range(0, 2);
        for (int i = 0; i < trig_len; i++)
            push_tick(flavor == 1, i == 0);
        if (flavor == 2)
            push_tick(1'b0, 1'b0);
        for (int i = 0; i < cfg_timeout + 2; i++)
            push_tick(flavor != 0, 1'b0);
        push_tick(1'b0, 1'b0);
    endtask

    task automatic queue_random_phase(input int n_items);
        int pick;
        while (tick_q.size() < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                queue_measurement($urandom_range(0, 10),
                                  ($urandom_range(0, 4) == 0) ? $urandom_range(31, 250)
                                                              : $urandom_range(1, 30));
            else if (pick < 85)
                repeat ($urandom_range(1, 20)) push_tick(1'($urandom_range(0, 1)),
                                                         1'($urandom_range(0, 1)));
            else
                queue_timeout_run();
        end
    endtask

    // main sequence
    initial
    begin : stimulus
        int          drain_wait;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] scale;
        logic [31:0] swap;

        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // reset settings: echo high through the trigger must wait for a new rise,
        // start while busy is ignored
        push_tick(1'b1, 1'b1);
        repeat (9) push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        wait_drained();

        // zero trigger and zero timeout both act as one tick
        program_ranger(0, 0, 0, 0, 999);
        for (int i = REG_MAX_CM + 1; i < 8; i++)
            apb_write(i[2:0], $urandom());
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        wait_drained();

        // all-ones writes are cut to register width; trigger shortened mid-pulse
        program_ranger(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 999, 999);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        wait_drained();
        apb_write(REG_TRIGGER_TICKS, 1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);

        // randomized measurements under several settings
        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            case ($urandom_range(0, 3))
                0: scale = 24'hFF_FFFF;
                1: scale = SCALE_Q24_RST;
                2: scale = $urandom_range(0, 24'hFF_FFFF);
                default: scale = $urandom_range(24'h40_0000, 24'hFF_FFFF);
            endcase
            lo = $urandom_range(0, 200);
            hi = $urandom_range(lo, 999);
            if ($urandom_range(0, 4) == 0)
            begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
            program_ranger(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                           $urandom_range(20, 200), scale, lo, hi);
            steady = (p == 2);
            queue_random_phase(200);
        end

        // final drain with a bound
        while (tick_q.size() != 0 || s_axis_tvalid) @(posedge clk);
        drain_wait = 0;
        while (pending_readings.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
            $display("%0d readings never arrived", pending_readings.size());
        mismatch_count += pending_readings.size();

        $display("run covered %0d ticks and %0d readings: %0d echoes timed, %0d timeouts",
                 ticks_taken, results_seen, meas_done, meas_timeout);
        $display("register writes: %0d, mismatches: %0d", cfg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
